// ----- src/lstk_pkg.sv -----
// Shared types, codes and constants for the LIFO stack with search and remove.
package lstk_pkg;

	// Field widths of the stream items
	localparam int DATA_W      = 32;
	localparam int POS_W       = 5;
	localparam int FUNC_W      = 3;
	localparam int CNT_OUT_W   = 5;
	localparam int STAT_W      = 3;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 112;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (3 * DATA_W + CNT_OUT_W + 3 + STAT_W);

	// Default stack depth
	localparam int DEPTH_DEF = 16;

	// Operation codes carried in the input tuser
	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH   = 3'd0,
		FN_POP    = 3'd1,
		FN_REMOVE = 3'd2,
		FN_DELETE = 3'd3,
		FN_QUERY  = 3'd4
	} func_t;

	// Status codes reported with every result item
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_RD_TOP,
		S_RD_BOT,
		S_RD_MID,
		S_CAPT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic              load;
		logic              push_wr;
		logic              pop_dec;
		logic              set_status;
		logic [STAT_W-1:0] status_code;
		logic              set_found;
		logic              scan_init;
		logic              scan_step;
		logic              shift_from_pos;
		logic              shift_from_hit;
		logic              shift_step;
		logic              dec_count;
		logic              rd_top;
		logic              rd_bot;
		logic              rd_mid;
		logic              out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              empty;
		logic              full;
		logic              pos_bad;
		logic              scan_hit;
		logic              scan_miss;
		logic              shift_done;
		logic              out_free;
	} dp_sts_t;

endpackage

// ----- src/lstk_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module lstk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/lstk_dp.sv -----
// Datapath of the stack: entry memory, fill count, shared scan and shift pointer, result register.
module lstk_dp #(
	parameter int DEPTH = lstk_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [lstk_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic [lstk_pkg::FUNC_W-1:0]        s_tuser,
	input  lstk_pkg::dp_cmd_t                  cmd,
	output lstk_pkg::dp_sts_t                  sts,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic [lstk_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	import lstk_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [FUNC_W-1:0]        func_q;
	logic signed [DATA_W-1:0] val_q;
	logic [POS_W-1:0]         pos_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         ptr_q;
	logic                     more_q;
	logic                     rd_vld_q;
	logic [IDX_W-1:0]         rd_idx_q;
	logic [STAT_W-1:0]        status_q;
	logic                     found_q;
	logic                     pop_ok_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] bot_q;
	logic                     out_vld_q;
	logic [OUT_TDATA_W-1:0]   out_data_q;

	logic                     ram_wr_en;
	logic [IDX_W-1:0]         ram_wr_addr;
	logic [DATA_W-1:0]        ram_wr_data;
	logic                     ram_rd_en;
	logic [IDX_W-1:0]         ram_rd_addr;
	logic [DATA_W-1:0]        ram_rd_data;

	logic                     scan_iss;
	logic                     shift_iss;
	logic [CNT_W-1:0]         cnt_m1;
	logic [CNT_W-1:0]         mid_idx;
	logic [IDX_W-1:0]         top_addr;
	logic                     nonempty;
	logic                     is_full;
	logic                     scan_hit;

	// Entry storage
	lstk_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Derived values
	assign cnt_m1    = count_q - 1'b1;
	assign mid_idx   = cnt_m1 >> 1;
	assign top_addr  = pop_ok_q ? count_q[IDX_W-1:0] : cnt_m1[IDX_W-1:0];
	assign nonempty  = (count_q != '0);
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign scan_iss  = cmd.scan_step && more_q;
	assign shift_iss = cmd.shift_step && (ptr_q < count_q);
	assign scan_hit  = rd_vld_q && (ram_rd_data == val_q);

	// Memory port selection
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = count_q[IDX_W-1:0];
		ram_wr_data = val_q;
		ram_rd_en   = 1'b0;
		ram_rd_addr = ptr_q[IDX_W-1:0];
		if (cmd.push_wr) begin
			ram_wr_en = 1'b1;
		end else if (cmd.shift_step && rd_vld_q) begin
			// The entry read last cycle moves down one place
			ram_wr_en   = 1'b1;
			ram_wr_addr = rd_idx_q - 1'b1;
			ram_wr_data = ram_rd_data;
		end
		if (scan_iss || shift_iss) begin
			ram_rd_en = 1'b1;
		end else if (cmd.rd_top) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = top_addr;
		end else if (cmd.rd_bot) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = '0;
		end else if (cmd.rd_mid) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = mid_idx[IDX_W-1:0];
		end
	end

	// Captured input item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= s_tdata[DATA_W-1:0];
			pos_q <= s_tdata[DATA_W+POS_W-1:DATA_W];
		end
	end

	// Operation code and outcome flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q   <= '0;
			status_q <= ST_OK;
			found_q  <= 1'b0;
			pop_ok_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				func_q   <= s_tuser;
				status_q <= ST_OK;
				found_q  <= 1'b0;
				pop_ok_q <= 1'b0;
			end
			if (cmd.set_status) begin
				status_q <= cmd.status_code;
			end
			if (cmd.set_found) begin
				found_q <= 1'b1;
			end
			if (cmd.pop_dec) begin
				pop_ok_q <= 1'b1;
			end
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push_wr) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.pop_dec || cmd.dec_count) begin
			count_q <= cnt_m1;
		end
	end

	// Scan and shift pointer, with the tag of the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			more_q   <= 1'b0;
			rd_vld_q <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			rd_vld_q <= scan_iss || shift_iss;
			if (scan_iss || shift_iss) begin
				rd_idx_q <= ptr_q[IDX_W-1:0];
			end
			if (cmd.scan_init) begin
				ptr_q  <= cnt_m1;
				more_q <= 1'b1;
			end else if (cmd.shift_from_pos) begin
				ptr_q <= CNT_W'(pos_q);
			end else if (cmd.shift_from_hit) begin
				ptr_q <= CNT_W'(rd_idx_q) + 1'b1;
			end else if (scan_iss) begin
				// Scan walks down from the top so the first match is the highest
				if (ptr_q == '0) begin
					more_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q - 1'b1;
				end
			end else if (shift_iss) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// Report capture of top and bottom entries
	always_ff @(posedge clk) begin
		if (cmd.rd_bot) begin
			top_q <= ram_rd_data;
		end
		if (cmd.rd_mid) begin
			bot_q <= ram_rd_data;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {
				{OUT_PAD_W{1'b0}},
				status_q,
				found_q,
				is_full,
				!nonempty,
				CNT_OUT_W'(count_q),
				(nonempty ? ram_rd_data : {DATA_W{1'b0}}),
				(nonempty ? bot_q : {DATA_W{1'b0}}),
				((pop_ok_q || nonempty) ? top_q : {DATA_W{1'b0}})
			};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// Status to the controller
	always_comb begin
		sts.func       = func_q;
		sts.empty      = !nonempty;
		sts.full       = is_full;
		sts.pos_bad    = (pos_q == '0) || (CMP_W'(pos_q) > CMP_W'(count_q));
		sts.scan_hit   = scan_hit;
		sts.scan_miss  = rd_vld_q && !scan_hit && (rd_idx_q == '0);
		sts.shift_done = !(ptr_q < count_q) && !rd_vld_q;
		sts.out_free   = !out_vld_q || m_tready;
	end

endmodule

// ----- src/lstk_ctrl.sv -----
// Controller state machine that sequences each stack operation and its report.
module lstk_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output lstk_pkg::dp_cmd_t cmd,
	input  lstk_pkg::dp_sts_t sts
);

	import lstk_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_RD_TOP;
				unique case (sts.func) inside
					FN_PUSH: begin
						if (sts.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_FULL;
						end else begin
							cmd.push_wr = 1'b1;
						end
					end
					FN_POP: begin
						if (sts.empty) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_EMPTY;
						end else begin
							cmd.pop_dec = 1'b1;
						end
					end
					FN_REMOVE, FN_QUERY: begin
						if (sts.empty) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_EMPTY;
						end else begin
							cmd.scan_init = 1'b1;
							state_d       = S_SCAN;
						end
					end
					FN_DELETE: begin
						if (sts.empty) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_EMPTY;
						end else if (sts.pos_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_RANGE;
						end else begin
							cmd.shift_from_pos = 1'b1;
							state_d            = S_SHIFT;
						end
					end
					default: begin
						state_d = S_RD_TOP;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.scan_hit) begin
					cmd.set_found = 1'b1;
					if (sts.func == FN_REMOVE) begin
						cmd.shift_from_hit = 1'b1;
						state_d            = S_SHIFT;
					end else begin
						state_d = S_RD_TOP;
					end
				end else if (sts.scan_miss) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_NOTFOUND;
					state_d         = S_RD_TOP;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (sts.shift_done) begin
					cmd.dec_count = 1'b1;
					state_d       = S_RD_TOP;
				end
			end
			S_RD_TOP: begin
				cmd.rd_top = 1'b1;
				state_d    = S_RD_BOT;
			end
			S_RD_BOT: begin
				cmd.rd_bot = 1'b1;
				state_d    = S_RD_MID;
			end
			S_RD_MID: begin
				cmd.rd_mid = 1'b1;
				state_d    = S_CAPT;
			end
			S_CAPT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/lifo_stack_with_search_remove_core.sv -----
// Top level of the LIFO stack with search, remove and delete-by-position.
//
// Channel  Dir  Contents
// s_axis   in   tuser: func; tdata: data_value, position
// m_axis   out  tdata: result_value, bottom_entry, middle_entry, entry_count,
//               is_empty, is_full, found, status
//
// Push, pop and rejected commands pass through accept, execute, three memory reads
// and the output load. Remove and query add a scan; remove and delete add a shift
// of the entries above the gap, one per cycle.
// Reset clears the fill count and control; the entry memory is not cleared.
// A new item is taken while a result waits; the output load waits for a free register.
module lifo_stack_with_search_remove_core #(
	parameter int DEPTH = lstk_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [31:0] data_value, [36:32] position, [39:37] zero
	input  logic [lstk_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [2:0] func
	input  logic [lstk_pkg::FUNC_W-1:0]      s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] result_value, [63:32] bottom_entry, [95:64] middle_entry,
	// [100:96] entry_count, [101] is_empty, [102] is_full, [103] found,
	// [106:104] status, [111:107] zero
	output logic [lstk_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	import lstk_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer
	lstk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Storage and result path
	lstk_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_axis_tdata),
		.s_tuser  (s_axis_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tdata  (m_axis_tdata)
	);

	// A result never appears in the cycle right after an item is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
		else $error("result appeared one cycle after accept");

	// A stack cannot report empty and full together.
	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[101] && m_axis_tdata[102]))
		else $error("empty and full reported together");

	// A match is always reported with an ok status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[103]) |-> (m_axis_tdata[106:104] == ST_OK))
		else $error("found set with non-ok status");

	// The controller never writes a push into a full stack.
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> !sts.full)
		else $error("push written while full");

endmodule
